>>> hw/rtl/scsm_pkg.sv
`default_nettype none
package scsm_pkg;

  // sizes follow the four reading inputs; widths hold for any used count up to four
  localparam int DefaultSensorCount = 4;
  localparam int InputReadings      = 4;
  localparam int ReadingWidth       = 9;
  localparam int FactorWidth        = 8;
  localparam int CountWidth         = 3;
  localparam int SumWidth           = 11;
  localparam int DiffWidth          = 13;
  localparam int SqWidth            = 23;
  localparam int SqSumWidth         = 25;
  localparam int KsqWidth           = 16;
  localparam int ThreshWidth        = 41;
  localparam int ThreshScale        = 256;

  localparam logic [FactorWidth-1:0] FactorReset = 8'd16;

  typedef logic signed [ReadingWidth-1:0] reading_t;
  typedef logic [InputReadings-1:0] mask_t;

  // per-stage enables from the sequencer to the lanes
  typedef struct packed {
    logic sq_en;
    logic thr_en;
    logic cmp_en;
  } lane_ctrl_t;

  typedef enum logic [2:0] {
    StIdle,
    StSq,
    StThr,
    StCmp,
    StDone
  } state_e;

endpackage
`default_nettype wire

>>> hw/rtl/scsm_lane.sv
`default_nettype none
module scsm_lane import scsm_pkg::*; #(
  parameter int USED_COUNT = DefaultSensorCount
) (
  input  wire logic                          clk_i,
  input  wire lane_ctrl_t                    ctrl_i,
  input  wire reading_t                      reading_i,
  input  wire logic signed [SumWidth-1:0]    sum_i,
  input  wire logic [ThreshWidth-1:0]        thresh_i,
  output logic [SqWidth-1:0]                 dsq_o,
  output logic                               kept_o
);

  localparam logic signed [DiffWidth-1:0] NMul = DiffWidth'(USED_COUNT);
  localparam logic [ThreshWidth-1:0] LhsScale = ThreshWidth'(ThreshScale * USED_COUNT);

  logic signed [DiffWidth-1:0]   diff;
  logic signed [2*DiffWidth-1:0] prod;
  logic [SqWidth-1:0]            dsq_q;
  logic [ThreshWidth-1:0]        lhs_q;
  logic                          kept_q;

  // scaled deviation n*x - s and its square
  always_comb begin
    diff = NMul * DiffWidth'(reading_i) - DiffWidth'(sum_i);
    prod = (2*DiffWidth)'(diff) * (2*DiffWidth)'(diff);
  end

  // square, scaled left side, then compare against the shared threshold
  always_ff @(posedge clk_i) begin
    if (ctrl_i.sq_en) begin
      dsq_q <= prod[SqWidth-1:0];
    end
    if (ctrl_i.thr_en) begin
      lhs_q <= ThreshWidth'(dsq_q) * LhsScale;
    end
    if (ctrl_i.cmp_en) begin
      kept_q <= (lhs_q < thresh_i);
    end
  end

  assign dsq_o  = dsq_q;
  assign kept_o = kept_q;

endmodule
`default_nettype wire

>>> hw/rtl/scsm_merge.sv
`default_nettype none
module scsm_merge import scsm_pkg::*; #(
  parameter int USED_COUNT = DefaultSensorCount
) (
  input  wire reading_t [InputReadings-1:0] readings_i,
  input  wire mask_t                        kept_i,
  output reading_t                          mean_o,
  output logic                              none_kept_o
);

  localparam int Recip3      = 683;
  localparam int Recip3Shift = 11;

  // truncating divide of a small sum by 1..4, thirds through a reciprocal
  function automatic reading_t div_trunc(logic signed [SumWidth-1:0] num,
                                         logic [CountWidth-1:0] den);
    logic [SumWidth-1:0]   mag;
    logic [SumWidth-1:0]   quo;
    logic [2*SumWidth-1:0] prod;
    mag  = num[SumWidth-1] ? SumWidth'(-num) : SumWidth'(num);
    prod = '0;
    case (den)
      3'd2: quo = mag >> 1;
      3'd3: begin
        prod = (2*SumWidth)'(mag) * (2*SumWidth)'(Recip3);
        quo  = SumWidth'(prod >> Recip3Shift);
      end
      3'd4: quo = mag >> 2;
      default: quo = mag;
    endcase
    return num[SumWidth-1] ? reading_t'(-quo) : reading_t'(quo);
  endfunction

  logic signed [SumWidth-1:0] kept_sum;
  logic signed [SumWidth-1:0] all_sum;
  logic [CountWidth-1:0]      kept_cnt;

  // gather kept readings; fall back to the plain mean when none survive
  always_comb begin
    kept_sum = '0;
    all_sum  = '0;
    kept_cnt = '0;
    for (int i = 0; i < USED_COUNT; i++) begin
      all_sum = all_sum + SumWidth'(readings_i[i]);
      if (kept_i[i]) begin
        kept_sum = kept_sum + SumWidth'(readings_i[i]);
        kept_cnt = kept_cnt + 1'b1;
      end
    end
    none_kept_o = (kept_cnt == '0);
    if (none_kept_o) begin
      mean_o = div_trunc(all_sum, CountWidth'(USED_COUNT));
    end else begin
      mean_o = div_trunc(kept_sum, kept_cnt);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/sigma_clipped_sensor_mean_unit.sv
`default_nettype none
// Sigma-clipped mean of one set of thermistor readings. A set is taken when
// in_valid_i and in_ready_o are high; one result beat follows with the
// truncated mean of the readings within accuracy_factor/16 standard deviations,
// the kept mask, the sticky healthy mask and a flag for the case where no reading
// survived (the plain mean is given then). One lane per sensor forms the scaled
// deviation, its square and the comparison; a merge stage sums the kept readings
// and divides by the kept count. A set is registered with its sum at accept, then
// passes the square, threshold multiply and compare registers; the merge feeds the
// output register. No new set is taken until the last result is loaded there, and
// the next set is accepted while an earlier result still waits. cfg_we_i writes
// accuracy_factor from cfg_wdata_i and must only be used while the block is idle.
module sigma_clipped_sensor_mean_unit import scsm_pkg::*; #(
  parameter int SENSOR_COUNT = DefaultSensorCount
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [FactorWidth-1:0] cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire reading_t               reading_0_i,
  input  wire reading_t               reading_1_i,
  input  wire reading_t               reading_2_i,
  input  wire reading_t               reading_3_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output reading_t                    pod_temperature_o,
  output mask_t                       kept_mask_o,
  output mask_t                       healthy_mask_o,
  output logic                        none_kept_o
);

  localparam int UsedCount = (SENSOR_COUNT > InputReadings) ? InputReadings :
                             ((SENSOR_COUNT < 1) ? 1 : SENSOR_COUNT);
  localparam mask_t UsedMask = mask_t'((1 << UsedCount) - 1);
  localparam logic [KsqWidth-1:0] KsqReset = KsqWidth'(FactorReset) * KsqWidth'(FactorReset);

  state_e state_q, state_d;
  lane_ctrl_t lane_ctrl;

  reading_t [InputReadings-1:0]   rd_in;
  reading_t [InputReadings-1:0]   x_q;
  logic signed [SumWidth-1:0]     sum_in;
  logic signed [SumWidth-1:0]     sum_q;
  logic [KsqWidth-1:0]            ksq_q;
  logic [SqSumWidth-1:0]          sq_sum;
  logic [ThreshWidth-1:0]         thresh_q;
  logic [InputReadings-1:0][SqWidth-1:0] dsq;
  mask_t                          kept;
  reading_t                       mean;
  logic                           none_kept;
  logic                           in_acc;
  logic                           out_load;
  logic                           out_valid_q, out_valid_d;
  reading_t                       pod_q;
  mask_t                          kept_out_q;
  logic                           none_q;
  mask_t                          healthy_q, healthy_d;

  assign rd_in  = {reading_3_i, reading_2_i, reading_1_i, reading_0_i};
  assign in_acc = in_valid_i && in_ready_o;

  // sum of the used readings, taken with the beat
  always_comb begin
    sum_in = '0;
    for (int i = 0; i < UsedCount; i++) begin
      sum_in = sum_in + SumWidth'(rd_in[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q   <= rd_in;
      sum_q <= sum_in;
    end
  end

  // squared factor kept ready for the threshold multiply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksq_q <= KsqReset;
    end else if (cfg_we_i) begin
      ksq_q <= KsqWidth'(cfg_wdata_i) * KsqWidth'(cfg_wdata_i);
    end
  end

  // threshold k^2 times the sum of squared deviations
  always_comb begin
    sq_sum = '0;
    for (int i = 0; i < InputReadings; i++) begin
      sq_sum = sq_sum + SqSumWidth'(dsq[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (lane_ctrl.thr_en) begin
      thresh_q <= ThreshWidth'(ksq_q) * ThreshWidth'(sq_sum);
    end
  end

  // one lane per used sensor
  for (genvar i = 0; i < InputReadings; i++) begin : g_lane
    if (i < UsedCount) begin : g_used
      scsm_lane #(
        .USED_COUNT(UsedCount)
      ) u_lane (
        .clk_i    (clk_i),
        .ctrl_i   (lane_ctrl),
        .reading_i(x_q[i]),
        .sum_i    (sum_q),
        .thresh_i (thresh_q),
        .dsq_o    (dsq[i]),
        .kept_o   (kept[i])
      );
    end else begin : g_unused
      assign dsq[i]  = '0;
      assign kept[i] = 1'b0;
    end
  end

  scsm_merge #(
    .USED_COUNT(UsedCount)
  ) u_merge (
    .readings_i (x_q),
    .kept_i     (kept),
    .mean_o     (mean),
    .none_kept_o(none_kept)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    lane_ctrl.sq_en  = 1'b0;
    lane_ctrl.thr_en = 1'b0;
    lane_ctrl.cmp_en = 1'b0;
    out_load         = 1'b0;
    in_ready_o       = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = StSq;
        end
      end
      StSq: begin
        lane_ctrl.sq_en = 1'b1;
        state_d         = StThr;
      end
      StThr: begin
        lane_ctrl.thr_en = 1'b1;
        state_d          = StCmp;
      end
      StCmp: begin
        lane_ctrl.cmp_en = 1'b1;
        state_d          = StDone;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // output register and sticky health bits
  always_comb begin
    healthy_d   = healthy_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      healthy_d   = healthy_q & ~(~kept & UsedMask);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      healthy_q   <= '1;
    end else begin
      out_valid_q <= out_valid_d;
      healthy_q   <= healthy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pod_q      <= mean;
      kept_out_q <= kept;
      none_q     <= none_kept;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign pod_temperature_o = pod_q;
  assign kept_mask_o       = kept_out_q;
  assign healthy_mask_o    = healthy_q;
  assign none_kept_o       = none_q;

endmodule
`default_nettype wire

>>> hw/rtl/scsm_checker.sv
`default_nettype none
module scsm_checker import scsm_pkg::*; #(
  parameter int SENSOR_COUNT = DefaultSensorCount
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire reading_t pod_temperature_o,
  input wire mask_t    kept_mask_o,
  input wire mask_t    healthy_mask_o,
  input wire logic     none_kept_o
);

  localparam int UsedCount = (SENSOR_COUNT > InputReadings) ? InputReadings :
                             ((SENSOR_COUNT < 1) ? 1 : SENSOR_COUNT);
  localparam mask_t UsedMask = mask_t'((1 << UsedCount) - 1);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pod_temperature_o) &&
      $stable(kept_mask_o) && $stable(healthy_mask_o) && $stable(none_kept_o))
    else $error("result beat changed while stalled");

  // fallback flag matches an empty kept mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (none_kept_o == (kept_mask_o == '0)))
    else $error("none_kept disagrees with kept_mask");

  // a rejected sensor is never reported healthy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((healthy_mask_o & ~kept_mask_o & UsedMask) == '0))
    else $error("rejected sensor still marked healthy");

  // one set in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second set taken while one is in flight");

endmodule

bind sigma_clipped_sensor_mean_unit scsm_checker #(
  .SENSOR_COUNT(SENSOR_COUNT)
) u_scsm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .pod_temperature_o(pod_temperature_o),
  .kept_mask_o      (kept_mask_o),
  .healthy_mask_o   (healthy_mask_o),
  .none_kept_o      (none_kept_o)
);
`default_nettype wire

>>> tb/tb_sigma_clipped_sensor_mean_unit.sv
`default_nettype none
module tb_sigma_clipped_sensor_mean_unit;
  import scsm_pkg::*;

  localparam int SensorCount     = DefaultSensorCount;
  localparam int DirectedSets    = 18;
  localparam int RandomPhases    = 6;
  localparam int SetsPerPhase    = 125;
  localparam int ShownMismatches = 10;
  localparam int NoWrite         = -1;

  // one expected result beat
  typedef struct {
    reading_t temp;
    mask_t    kept;
    mask_t    healthy;
    logic     none;
  } pod_result_t;

  // predicts the clipped mean per reading set and checks result beats in order
  class clip_scoreboard;
    logic [FactorWidth-1:0] factor;
    mask_t                  healthy;
    pod_result_t            expected_q[$];
    int                     mismatches;

    function new();
      factor     = FactorReset;
      healthy    = '1;
      mismatches = 0;
    endfunction

    function void set_factor(logic [FactorWidth-1:0] value);
      factor = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // exact integer outlier test, then truncated mean of the survivors
    function void note_set(reading_t r0, reading_t r1, reading_t r2, reading_t r3);
      longint      x[InputReadings];
      longint      dev[InputReadings];
      longint      total, sq_sum, thresh, lhs, kept_sum, mean;
      int          n, kept_cnt;
      pod_result_t res;
      x[0] = longint'(r0);
      x[1] = longint'(r1);
      x[2] = longint'(r2);
      x[3] = longint'(r3);
      n = (SensorCount < InputReadings) ? SensorCount : InputReadings;
      if (n < 1) n = 1;
      total = 0;
      for (int i = 0; i < n; i++) total += x[i];
      sq_sum = 0;
      for (int i = 0; i < n; i++) begin
        dev[i] = longint'(n) * x[i] - total;
        sq_sum += dev[i] * dev[i];
      end
      thresh   = longint'(factor) * longint'(factor) * sq_sum;
      res.kept = '0;
      kept_sum = 0;
      kept_cnt = 0;
      for (int i = 0; i < n; i++) begin
        lhs = longint'(ThreshScale) * longint'(n) * dev[i] * dev[i];
        if (lhs < thresh) begin
          res.kept[i] = 1'b1;
          kept_sum += x[i];
          kept_cnt++;
        end else begin
          healthy[i] = 1'b0;
        end
      end
      // no survivor: fall back to the plain mean of all used readings
      if (kept_cnt > 0) mean = kept_sum / longint'(kept_cnt);
      else mean = total / longint'(n);
      res.temp    = reading_t'(mean);
      res.healthy = healthy;
      res.none    = (kept_cnt == 0);
      expected_q.push_back(res);
    endfunction

    function void check_beat(reading_t temp, mask_t kept, mask_t healthy_seen, logic none);
      pod_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ShownMismatches)
          $display("unexpected result beat: temp %0d kept %b healthy %b none %b",
                   temp, kept, healthy_seen, none);
      end else begin
        want = expected_q.pop_front();
        if (temp !== want.temp || kept !== want.kept || healthy_seen !== want.healthy ||
            none !== want.none) begin
          mismatches++;
          if (mismatches <= ShownMismatches)
            $display("mismatch: want %0d %b %b %b, got %0d %b %b %b",
                     want.temp, want.kept, want.healthy, want.none,
                     temp, kept, healthy_seen, none);
        end
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [FactorWidth-1:0] cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  reading_t               reading_0_i;
  reading_t               reading_1_i;
  reading_t               reading_2_i;
  reading_t               reading_3_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  reading_t               pod_temperature_o;
  mask_t                  kept_mask_o;
  mask_t                  healthy_mask_o;
  logic                   none_kept_o;

  clip_scoreboard sb;
  int unsigned    tx_idle_pct;
  int unsigned    rx_idle_pct;

  // directed sets, with a factor write ahead of some of them
  int directed_sets [DirectedSets][InputReadings] = '{
    '{0, 1, 2, 3},         '{10, 10, 10, 200},    '{-1, -1, -1, -2},
    '{-3, -4, 5, 100},     '{255, 0, 0, 0},       '{-256, 255, -256, 255},
    '{-256, -256, -256, 255}, '{-256, -256, -256, -256}, '{255, 255, 255, 255},
    '{-256, 255, -256, 255}, '{1, 2, 3, 4},       '{100, -100, 7, 7},
    '{5, 5, 5, 5},         '{-256, 255, 0, -1},
    '{1, 2, 3, 4},         '{-256, 255, -256, 255},
    '{0, 0, 0, 1},         '{-7, 8, -9, 10}
  };
  int directed_factor [DirectedSets] = '{
    NoWrite, NoWrite, NoWrite, NoWrite, NoWrite, NoWrite, NoWrite, NoWrite, NoWrite,
    255, NoWrite, NoWrite, NoWrite, NoWrite,
    0, NoWrite,
    1, NoWrite
  };
  // factor per random phase; the last one is drawn at random
  int phase_factor [RandomPhases] = '{32, 255, 1, 24, 12, 16};

  sigma_clipped_sensor_mean_unit #(
    .SENSOR_COUNT(SensorCount)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .reading_0_i      (reading_0_i),
    .reading_1_i      (reading_1_i),
    .reading_2_i      (reading_2_i),
    .reading_3_i      (reading_3_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pod_temperature_o(pod_temperature_o),
    .kept_mask_o      (kept_mask_o),
    .healthy_mask_o   (healthy_mask_o),
    .none_kept_o      (none_kept_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // both handshakes are settled at the falling edge; the beat moves at the next rise
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_set(reading_0_i, reading_1_i, reading_2_i, reading_3_i);
      if (out_valid_o && out_ready_i)
        sb.check_beat(pod_temperature_o, kept_mask_o, healthy_mask_o, none_kept_o);
    end
  end

  // result side back-pressure
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // clamp to the reading range
  function automatic int clamp_reading(int v);
    if (v > 255) return 255;
    if (v < -256) return -256;
    return v;
  endfunction

  // one reading set beat, with random gaps ahead of it
  task automatic send_set(input int a, input int b, input int c, input int d);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    reading_0_i <= reading_t'(a);
    reading_1_i <= reading_t'(b);
    reading_2_i <= reading_t'(c);
    reading_3_i <= reading_t'(d);
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  // factor write once all results are out
  task automatic write_factor(input logic [FactorWidth-1:0] value);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_factor(value);
  endtask

  // stimulus
  initial begin
    int vals[InputReadings];
    int kind, base, mode;
    sb          = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    reading_0_i = '0;
    reading_1_i = '0;
    reading_2_i = '0;
    reading_3_i = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed sets: extremes, equal readings, negative truncation, zero factor
    for (int i = 0; i < DirectedSets; i++) begin
      if (directed_factor[i] != NoWrite) write_factor(FactorWidth'(directed_factor[i]));
      send_set(directed_sets[i][0], directed_sets[i][1],
               directed_sets[i][2], directed_sets[i][3]);
    end

    // random phases
    for (int p = 0; p < RandomPhases; p++) begin
      if (p == RandomPhases - 1) write_factor(FactorWidth'($urandom_range(0, 255)));
      else write_factor(FactorWidth'(phase_factor[p]));
      mode = p / 2;
      tx_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 60 : 0;
      rx_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 27 : 0;
      for (int i = 0; i < SetsPerPhase; i++) begin
        // sender holds off until the pipe has fully drained
        if (p == 1 && i == SetsPerPhase / 2) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (sb.pending() != 0) @(posedge clk_i);
        end
        kind = $urandom_range(0, 99);
        base = int'($urandom_range(0, 511)) - 256;
        for (int j = 0; j < InputReadings; j++) begin
          if (kind < 60) begin
            vals[j] = clamp_reading(base + int'($urandom_range(0, 8)) - 4);
          end else if (kind < 75) begin
            vals[j] = int'($urandom_range(0, 511)) - 256;
          end else if (kind < 85) begin
            vals[j] = base;
          end else begin
            case ($urandom_range(0, 3))
              0: vals[j] = -256;
              1: vals[j] = 255;
              2: vals[j] = -1;
              default: vals[j] = 0;
            endcase
          end
        end
        // tight cluster with one far outlier
        if (kind < 60 && $urandom_range(0, 1) == 1)
          vals[$urandom_range(0, InputReadings - 1)] = int'($urandom_range(0, 511)) - 256;
        send_set(vals[0], vals[1], vals[2], vals[3]);
      end
    end

    // drain and let the pipe settle
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
